// File: rtl/bounded_double_ended_queue_assert.svh
// assertion macros shared by the checker
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define BDEQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define BDEQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/bdeq_pkg.sv
package bdeq_pkg;

   // queue geometry
   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // fixed transaction field widths
   localparam int KIND_W  = 3;
   localparam int VALUE_W = 32;
   localparam int INDEX_W = 4;
   localparam int COUNT_W = 5;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_TAIL    = 3'd0,
      KIND_POP_HEAD     = 3'd1,
      KIND_POP_TAIL     = 3'd2,
      KIND_PEEK_HEAD    = 3'd3,
      KIND_PEEK_TAIL    = 3'd4,
      KIND_PEEK_NTH     = 3'd5,
      KIND_REMOVE_VALUE = 3'd6,
      KIND_CLEAR        = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   // read offset source, relative to the head
   typedef enum logic [2:0] {
      RD_HEAD = 3'd0,
      RD_TAIL = 3'd1,
      RD_NTH  = 3'd2,
      RD_NEXT = 3'd3
   } rd_sel_type;

   typedef enum logic {
      WR_PUSH  = 1'b0,
      WR_SHIFT = 1'b1
   } wr_sel_type;

   typedef struct packed {
      logic       latch;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       head_adv;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       clear;
      logic       pos_clear;
      logic       pos_inc;
      logic       rsp_load;
      logic       rsp_use_mem;
      logic       rsp_found;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     full;
      logic     empty;
      logic     idx_miss;
      logic     match;
      logic     pos_last;
   } stat_type;

endpackage

// File: rtl/bdeq_req_if.sv
interface bdeq_req_if;
   logic                              valid;
   logic                              ready;
   bdeq_pkg::kind_type                kind;
   logic [bdeq_pkg::VALUE_W-1:0]      value;
   logic [bdeq_pkg::INDEX_W-1:0]      index;

   modport source (output valid, output kind, output value, output index, input ready);
   modport sink   (input valid, input kind, input value, input index, output ready);
endinterface

// File: rtl/bdeq_rsp_if.sv
interface bdeq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [bdeq_pkg::VALUE_W-1:0]      data_out;
   logic                              found;
   bdeq_pkg::status_type              status;
   logic [bdeq_pkg::COUNT_W-1:0]      count;

   modport source (output valid, output data_out, output found, output status,
                   output count, input ready);
   modport sink   (input valid, input data_out, input found, input status,
                   input count, output ready);
endinterface

// File: rtl/bdeq_ctrl.sv
module bdeq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  bdeq_pkg::stat_type stat,
   output bdeq_pkg::cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_EXEC  = 6'b000010,
      S_READ  = 6'b000100,
      S_SCAN  = 6'b001000,
      S_SHIFT = 6'b010000,
      S_MOVE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            unique case (stat.kind)
               bdeq_pkg::KIND_PUSH_TAIL: begin
                  cmd.rsp_load = 1'b1;
                  if (stat.full) begin
                     cmd.rsp_status = bdeq_pkg::STAT_FULL;
                  end else begin
                     cmd.wr_en      = 1'b1;
                     cmd.wr_sel     = bdeq_pkg::WR_PUSH;
                     cmd.cnt_inc    = 1'b1;
                     cmd.rsp_status = bdeq_pkg::STAT_OK;
                  end
               end
               bdeq_pkg::KIND_POP_HEAD, bdeq_pkg::KIND_PEEK_HEAD: begin
                  if (stat.empty) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = bdeq_pkg::STAT_MISS;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = bdeq_pkg::RD_HEAD;
                     if (stat.kind == bdeq_pkg::KIND_POP_HEAD) begin
                        cmd.head_adv = 1'b1;
                        cmd.cnt_dec  = 1'b1;
                     end
                     state_in = S_READ;
                  end
               end
               bdeq_pkg::KIND_POP_TAIL, bdeq_pkg::KIND_PEEK_TAIL: begin
                  if (stat.empty) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = bdeq_pkg::STAT_MISS;
                  end else begin
                     cmd.rd_en   = 1'b1;
                     cmd.rd_sel  = bdeq_pkg::RD_TAIL;
                     cmd.cnt_dec = (stat.kind == bdeq_pkg::KIND_POP_TAIL);
                     state_in    = S_READ;
                  end
               end
               bdeq_pkg::KIND_PEEK_NTH: begin
                  if (stat.idx_miss) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = bdeq_pkg::STAT_MISS;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = bdeq_pkg::RD_NTH;
                     state_in   = S_READ;
                  end
               end
               bdeq_pkg::KIND_REMOVE_VALUE: begin
                  if (stat.empty) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = bdeq_pkg::STAT_MISS;
                  end else begin
                     cmd.pos_clear = 1'b1;
                     cmd.rd_en     = 1'b1;
                     cmd.rd_sel    = bdeq_pkg::RD_HEAD;
                     state_in      = S_SCAN;
                  end
               end
               bdeq_pkg::KIND_CLEAR: begin
                  cmd.clear      = 1'b1;
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = bdeq_pkg::STAT_OK;
               end
            endcase
         end
         S_READ: begin
            cmd.rsp_load    = 1'b1;
            cmd.rsp_use_mem = 1'b1;
            cmd.rsp_found   = 1'b1;
            cmd.rsp_status  = bdeq_pkg::STAT_OK;
            state_in        = S_IDLE;
         end
         S_SCAN: begin
            if (stat.match) begin
               state_in = S_SHIFT;
            end else if (!stat.pos_last) begin
               cmd.pos_inc = 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = bdeq_pkg::RD_NEXT;
            end else begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = bdeq_pkg::STAT_MISS;
               state_in       = S_IDLE;
            end
         end
         S_SHIFT: begin
            if (!stat.pos_last) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = bdeq_pkg::RD_NEXT;
               state_in   = S_MOVE;
            end else begin
               cmd.cnt_dec    = 1'b1;
               cmd.rsp_load   = 1'b1;
               cmd.rsp_found  = 1'b1;
               cmd.rsp_status = bdeq_pkg::STAT_OK;
               state_in       = S_IDLE;
            end
         end
         S_MOVE: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = bdeq_pkg::WR_SHIFT;
            cmd.pos_inc = 1'b1;
            state_in    = S_SHIFT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/bdeq_dpath.sv
module bdeq_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  bdeq_pkg::kind_type                req_kind,
   input  logic [bdeq_pkg::VALUE_W-1:0]      req_value,
   input  logic [bdeq_pkg::INDEX_W-1:0]      req_index,
   input  bdeq_pkg::cmd_type                 cmd,
   output bdeq_pkg::stat_type                stat,
   output logic [bdeq_pkg::VALUE_W-1:0]      rsp_data_out,
   output logic                              rsp_found,
   output bdeq_pkg::status_type              rsp_status,
   output logic [bdeq_pkg::COUNT_W-1:0]      rsp_count
);

   localparam int PTR_W  = bdeq_pkg::PTR_W;
   localparam int CNT_W  = bdeq_pkg::CNT_W;
   localparam int DATA_W = bdeq_pkg::DATA_W;

   // store slot of the entry at offset off from the head
   function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(bdeq_pkg::DEPTH)) begin
         sum = sum - (CNT_W+1)'(bdeq_pkg::DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   logic [DATA_W-1:0]            mem [bdeq_pkg::DEPTH];
   bdeq_pkg::kind_type           kind_ff;
   logic [DATA_W-1:0]            value_ff;
   logic [bdeq_pkg::INDEX_W-1:0] index_ff;
   logic [PTR_W-1:0]             head_ff, head_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [CNT_W-1:0]             pos_ff;
   logic [DATA_W-1:0]            rd_data_ff;
   logic [CNT_W-1:0]             rd_off;
   logic [PTR_W-1:0]             rd_addr, wr_addr;
   logic [DATA_W-1:0]            wr_data;
   logic [CNT_W-1:0]             pos_next;

   logic [bdeq_pkg::VALUE_W-1:0] rsp_data_ff;
   logic                         rsp_found_ff;
   bdeq_pkg::status_type         rsp_status_ff;
   logic [bdeq_pkg::COUNT_W-1:0] rsp_count_ff;

   assign pos_next = pos_ff + CNT_W'(1);

   always_comb begin
      case (cmd.rd_sel)
         bdeq_pkg::RD_HEAD: rd_off = '0;
         bdeq_pkg::RD_TAIL: rd_off = count_ff - CNT_W'(1);
         bdeq_pkg::RD_NTH:  rd_off = CNT_W'(index_ff);
         bdeq_pkg::RD_NEXT: rd_off = pos_next;
         default:           rd_off = '0;
      endcase
   end

   assign rd_addr = slot_of(head_ff, rd_off);
   assign wr_addr = (cmd.wr_sel == bdeq_pkg::WR_SHIFT) ? slot_of(head_ff, pos_ff)
                                                      : slot_of(head_ff, count_ff);
   assign wr_data = (cmd.wr_sel == bdeq_pkg::WR_SHIFT) ? rd_data_ff : value_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.clear) begin
         head_in  = '0;
         count_in = '0;
      end else begin
         if (cmd.head_adv) begin
            head_in = slot_of(head_ff, CNT_W'(1));
         end
         if (cmd.cnt_inc) begin
            count_in = count_ff + CNT_W'(1);
         end else if (cmd.cnt_dec) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff  <= req_kind;
         value_ff <= req_value[DATA_W-1:0];
         index_ff <= req_index;
      end
      if (cmd.pos_clear) begin
         pos_ff <= '0;
      end else if (cmd.pos_inc) begin
         pos_ff <= pos_next;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff   <= cmd.rsp_use_mem ? bdeq_pkg::VALUE_W'(rd_data_ff) : '0;
         rsp_found_ff  <= cmd.rsp_found;
         rsp_status_ff <= cmd.rsp_status;
         rsp_count_ff  <= bdeq_pkg::COUNT_W'(count_in);
      end
   end

   assign stat.kind     = kind_ff;
   assign stat.full     = (count_ff == CNT_W'(bdeq_pkg::DEPTH));
   assign stat.empty    = (count_ff == '0);
   assign stat.idx_miss = ((CNT_W+1)'(index_ff) >= (CNT_W+1)'(count_ff));
   assign stat.match    = (rd_data_ff == value_ff);
   assign stat.pos_last = ((CNT_W+1)'(pos_ff) + (CNT_W+1)'(1) >= (CNT_W+1)'(count_ff));

   assign rsp_data_out = rsp_data_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

// File: rtl/bounded_double_ended_queue.sv
// accept to response valid: push, clear and misses answer from the decode state; pops
// and peeks answer after the registered store read; remove reads from the head until
// it finds the value, then moves each later entry up one place and then answers; an
// absent value is reported once the scan passes the last entry; one transaction in
// flight, taken only while idle with no response waiting or one taken in the same cycle
// reset (synchronous): head, count, sequencer and response valid cleared; store not cleared
module bounded_double_ended_queue (
   input logic        clock,
   input logic        reset,
   bdeq_req_if.sink   req_bus,
   bdeq_rsp_if.source rsp_bus
);

   // command and status between sequencer and datapath
   bdeq_pkg::cmd_type  cmd;
   bdeq_pkg::stat_type stat;

   // sequencer: decodes the latched transaction, walks the search and
   // compaction loops, and owns both handshakes
   bdeq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: circular store with registered read, head/count pointers,
   // scan position and the response holding register
   bdeq_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_kind     (req_bus.kind),
      .req_value    (req_bus.value),
      .req_index    (req_bus.index),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_data_out (rsp_bus.data_out),
      .rsp_found    (rsp_bus.found),
      .rsp_status   (rsp_bus.status),
      .rsp_count    (rsp_bus.count)
   );

endmodule

// File: rtl/bdeq_checker.sv
`include "bounded_double_ended_queue_assert.svh"

module bdeq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [bdeq_pkg::VALUE_W-1:0]      rsp_data_out,
   input logic                              rsp_found,
   input logic [1:0]                        rsp_status,
   input logic [bdeq_pkg::COUNT_W-1:0]      rsp_count
);

   // a stalled response holds
   `BDEQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_out) && $stable(rsp_count), "stalled response changed")

   // count never passes capacity
   `BDEQ_ASSERT_NOW(a_count_bound, rsp_valid, rsp_count <= bdeq_pkg::COUNT_W'(bdeq_pkg::DEPTH), "count above depth")

   // a rejected push only happens on a full queue
   `BDEQ_ASSERT_NOW(a_full_reject, rsp_valid && (rsp_status == bdeq_pkg::STAT_FULL), (rsp_count == bdeq_pkg::COUNT_W'(bdeq_pkg::DEPTH)) && !rsp_found, "full status on non-full queue")

   // found implies ok status
   `BDEQ_ASSERT_NOW(a_found_ok, rsp_valid && rsp_found, rsp_status == bdeq_pkg::STAT_OK, "found with error status")

   // a fresh transaction never sees a stale response the cycle after
   `BDEQ_ASSERT_NEXT(a_accept_gap, req_valid && req_ready, !rsp_valid, "response present right after accept")

endmodule

bind bounded_double_ended_queue bdeq_checker u_bdeq_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_data_out (rsp_bus.data_out),
   .rsp_found    (rsp_bus.found),
   .rsp_status   (rsp_bus.status),
   .rsp_count    (rsp_bus.count)
);

// File: sim/bdeq_reply_scoreboard.sv
module bdeq_reply_scoreboard
   import bdeq_pkg::*;
(
   input  logic clock,
   input  logic reset,
   bdeq_req_if  req_mon,
   bdeq_rsp_if  rsp_mon,
   output int   fail_count,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [VALUE_W-1:0] data_out;
      logic               found;
      status_type         status;
      logic [COUNT_W-1:0] count;
   } reply_t;

   // queue contents in order, head first
   logic [DATA_W-1:0] held_words[$];
   reply_t            pending_replies[$];
   int                reply_num;

   task automatic report_mismatch(string msg);
      $display("ERROR @%0t reply %0d: %s", $realtime, reply_num, msg);
      fail_count++;
   endtask

   // applies one request to the queue copy and returns the reply it should give
   function automatic reply_t serve_request(kind_type kind, logic [VALUE_W-1:0] value,
                                            logic [INDEX_W-1:0] index);
      reply_t            r;
      logic [DATA_W-1:0] word;
      int                hit;
      word       = value[DATA_W-1:0];
      hit        = -1;
      r.data_out = '0;
      r.found    = 1'b0;
      r.status   = STAT_OK;
      case (kind)
         KIND_PUSH_TAIL: begin
            if (held_words.size() >= DEPTH)
               r.status = STAT_FULL;
            else
               held_words.push_back(word);
         end
         KIND_POP_HEAD, KIND_POP_TAIL, KIND_PEEK_HEAD, KIND_PEEK_TAIL: begin
            if (held_words.size() == 0) begin
               r.status = STAT_MISS;
            end else begin
               r.found = 1'b1;
               case (kind)
                  KIND_POP_HEAD:  r.data_out = VALUE_W'(held_words.pop_front());
                  KIND_POP_TAIL:  r.data_out = VALUE_W'(held_words.pop_back());
                  KIND_PEEK_HEAD: r.data_out = VALUE_W'(held_words[0]);
                  default:        r.data_out = VALUE_W'(held_words[held_words.size() - 1]);
               endcase
            end
         end
         KIND_PEEK_NTH: begin
            if (int'(index) >= held_words.size()) begin
               r.status = STAT_MISS;
            end else begin
               r.found    = 1'b1;
               r.data_out = VALUE_W'(held_words[index]);
            end
         end
         KIND_REMOVE_VALUE: begin
            foreach (held_words[i])
               if (hit < 0 && held_words[i] == word)
                  hit = i;
            if (hit < 0) begin
               r.status = STAT_MISS;
            end else begin
               held_words.delete(hit);
               r.found = 1'b1;
            end
         end
         default: held_words.delete();
      endcase
      r.count = COUNT_W'(held_words.size());
      return r;
   endfunction

   always @(posedge clock) begin
      reply_t want;
      if (!reset) begin
         // replies first: a request accepted now cannot be answered in the same cycle
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_replies.size() == 0) begin
               report_mismatch($sformatf("reply with nothing pending, data_out=%h",
                                         rsp_mon.data_out));
            end else begin
               want = pending_replies.pop_front();
               if (rsp_mon.data_out !== want.data_out)
                  report_mismatch($sformatf("data_out %h, predicted %h",
                                            rsp_mon.data_out, want.data_out));
               if (rsp_mon.found !== want.found)
                  report_mismatch($sformatf("found %b, predicted %b",
                                            rsp_mon.found, want.found));
               if (rsp_mon.status !== want.status)
                  report_mismatch($sformatf("status %0d, predicted %0d",
                                            rsp_mon.status, want.status));
               if (rsp_mon.count !== want.count)
                  report_mismatch($sformatf("count %0d, predicted %0d",
                                            rsp_mon.count, want.count));
            end
            reply_num++;
         end
         if (req_mon.valid && req_mon.ready)
            pending_replies.push_back(serve_request(req_mon.kind, req_mon.value,
                                                    req_mon.index));
      end
      outstanding <= pending_replies.size();
   end

   final begin
      foreach (pending_replies[i])
         report_mismatch("reply never arrived");
   end

endmodule

// File: sim/tb_bounded_double_ended_queue.sv
module tb_bounded_double_ended_queue;
   timeunit 1ns;
   timeprecision 1ps;
   import bdeq_pkg::*;

   // timeout, far above the slowest legal run
   localparam int CYCLE_LIMIT  = 400000;
   // long receiver hold-off that backs the block up
   localparam int HOLD_CYCLES  = 300;
   // a remove can search and compact the whole store
   localparam int DRAIN_CYCLES = 3 * DEPTH + 8;

   logic clock = 1'b0;
   logic reset;

   // idle chances in percent, set per phase by the stimulus
   int idle_pct;
   int stall_pct;
   // receiver hold-off request, counted down by the receiver itself
   int hold_left;
   int fail_count;
   int outstanding;
   int cycle_count;

   // small pool of words so removes and duplicates hit often
   logic [VALUE_W-1:0] word_pool[8];

   // no idling, sender idle, receiver stalling, both
   int idle_plan[4]  = '{0, 50, 0, 38};
   int stall_plan[4] = '{0, 0, 50, 38};

   bdeq_req_if req_bus();
   bdeq_rsp_if rsp_bus();

   bounded_double_ended_queue dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   bdeq_reply_scoreboard reply_scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #4 clock = ~clock;

   // offer one transaction, with random idle cycles ahead of it, and wait for the handshake
   task automatic send_txn(kind_type kind, logic [VALUE_W-1:0] value,
                           logic [INDEX_W-1:0] index);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind  <= kind;
      req_bus.value <= value;
      req_bus.index <= index;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
   endtask

   // random transactions with weights for push and pop, the rest peeks, removes, clears
   task automatic send_mix(int n, int push_w, int pop_w);
      kind_type           kind;
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
      int                 roll;
      repeat (n) begin
         roll = $urandom_range(99);
         if (roll < push_w)
            kind = KIND_PUSH_TAIL;
         else if (roll < push_w + pop_w)
            kind = $urandom_range(1) ? KIND_POP_HEAD : KIND_POP_TAIL;
         else if (roll >= 97)
            kind = KIND_CLEAR;
         else
            kind = kind_type'($urandom_range(KIND_PEEK_HEAD, KIND_REMOVE_VALUE));
         // mostly pool words, sometimes a fresh word
         if ($urandom_range(9) < 7)
            value = word_pool[$urandom_range(7)];
         else
            value = VALUE_W'($urandom());
         // favor shallow positions, still sweep the whole index range
         if ($urandom_range(1))
            index = INDEX_W'($urandom_range(15));
         else
            index = INDEX_W'($urandom_range(3));
         send_txn(kind, value, index);
      end
   endtask

   // receiver: random stalls, or a counted hold-off when one is requested
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // watchdog on a cycle counter
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.kind  <= KIND_PUSH_TAIL;
      req_bus.value <= '0;
      req_bus.index <= '0;
      reset         <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reads of an empty queue
      send_txn(KIND_POP_HEAD, 32'h1357_9bdf, 4'd0);
      send_txn(KIND_PEEK_TAIL, 32'h0, 4'd0);
      send_txn(KIND_PEEK_NTH, 32'h0, 4'd0);

      // fill to the brim: extreme words and a duplicate pair for remove
      for (int i = 0; i < DEPTH; i++) begin
         if (i == 0)
            send_txn(KIND_PUSH_TAIL, '0, 4'd0);
         else if (i == 1)
            send_txn(KIND_PUSH_TAIL, '1, 4'd0);
         else if (i == 2 || i == 9)
            send_txn(KIND_PUSH_TAIL, 32'hdead_beef, 4'd0);
         else
            send_txn(KIND_PUSH_TAIL, VALUE_W'($urandom()), 4'd0);
      end

      // push into a full queue is rejected
      send_txn(KIND_PUSH_TAIL, 32'h5a5a_a5a5, 4'd0);
      // deepest position while full
      send_txn(KIND_PEEK_NTH, 32'h0, 4'd15);
      // first of two equal words goes, the rest close the gap
      send_txn(KIND_REMOVE_VALUE, 32'hdead_beef, 4'd0);
      // remove at the head
      send_txn(KIND_REMOVE_VALUE, '0, 4'd0);
      // absent word leaves the queue alone
      send_txn(KIND_REMOVE_VALUE, 32'h0bad_f00d, 4'd0);
      // index now past the count
      send_txn(KIND_PEEK_NTH, 32'h0, 4'd15);
      send_txn(KIND_POP_TAIL, 32'h0, 4'd0);
      send_txn(KIND_PEEK_HEAD, 32'h0, 4'd0);
      send_txn(KIND_CLEAR, 32'h0, 4'd0);
      // cleared queue reads as empty
      send_txn(KIND_PEEK_HEAD, 32'h0, 4'd0);

      // random: fill, churn and drain rounds under each idling mix
      for (int p = 0; p < 4; p++) begin
         idle_pct  = idle_plan[p];
         stall_pct = stall_plan[p];
         // receiver holds off for a long stretch while the sender keeps offering
         if (p == 0)
            hold_left = HOLD_CYCLES;
         repeat (4) begin
            foreach (word_pool[j])
               word_pool[j] = VALUE_W'($urandom());
            if ($urandom_range(1))
               word_pool[0] = '0;
            else
               word_pool[0] = '1;
            send_mix(25, 75, 5);
            send_mix(20, 30, 25);
            send_mix(15, 5, 65);
         end
      end

      // all transactions accepted, let the replies come home
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
